/* src/lfr_pkg.sv */
// ----------------------------------------------------------------------------
// lfr_pkg
// shared types and constants of the link frame receiver
// ----------------------------------------------------------------------------
package lfr_pkg;

    localparam int HEADER_BYTES  = 18;
    localparam int CAPTURE_DEPTH = 13;

    localparam int ADDR_W   = 48;
    localparam int DATA_W   = 176;
    localparam int PCT_W    = 7;
    localparam int DEVS_W   = 5;

    localparam logic [7:0] START_BYTE   = 8'h7e;
    localparam logic [7:0] CMD_DATA     = 8'h01;
    localparam logic [7:0] CMD_DATA_ALT = 8'h08;
    localparam logic [7:0] CMD_JOIN     = 8'h02;
    localparam logic [7:0] CMD_ADDR     = 8'h0A;
    localparam logic [7:0] CMD_DEVLIST  = 8'h05;
    localparam logic [7:0] CMD_SIGNAL   = 8'h04;
    localparam logic [7:0] JOIN_LEN     = 8'd13;
    localparam logic [7:0] DEVLIST_MIN  = 8'd16;
    localparam logic [7:0] SIGNAL_LEN   = 8'd6;
    localparam logic [7:0] SIGNAL_TAG   = 8'h05;
    localparam logic [14:0] SIGNAL_SCALE = 15'd100;
    localparam logic [ADDR_W-1:0] ADDR_ALL = {ADDR_W{1'b1}};

    typedef enum logic [1:0] {
        OP_BYTE,
        OP_TIMEOUT,
        OP_CONFIRM,
        OP_RESET
    } t_op;

    typedef enum logic [2:0] {
        KIND_PAYLOAD,
        KIND_EMPTY,
        KIND_LINK,
        KIND_SIGNAL,
        KIND_ERROR
    } t_kind;

    typedef enum logic [2:0] {
        LINK_IDLE,
        LINK_START,
        LINK_ADDR,
        LINK_DEVLIST,
        LINK_CONNECTED,
        LINK_ERROR
    } t_link;

    typedef struct packed {
        logic              valid;
        t_kind             kind;
        logic [7:0]        payload;
        logic              last;
        logic [7:0]        cmd;
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] own;
        logic [ADDR_W-1:0] peer;
        t_link             status;
        logic [DEVS_W-1:0] devices;
        logic [PCT_W-1:0]  pct;
    } t_beat;

endpackage

/* src/lfr_core.sv */
// ----------------------------------------------------------------------------
// lfr_core
// frame assembly, address filter and link state machine, one item per step
// ----------------------------------------------------------------------------
module lfr_core #(
    parameter int CAPTURE_DEPTH = lfr_pkg::CAPTURE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  lfr_pkg::t_op  i_op,
    input  logic [7:0]    i_byte,
    output lfr_pkg::t_beat o_beat
);

    localparam int CW = $clog2(CAPTURE_DEPTH);
    localparam int AW = lfr_pkg::ADDR_W;

    lfr_pkg::t_link r_link, n_link;
    logic [7:0]     r_pos, n_pos;
    logic [7:0]     r_len, n_len;
    logic [7:0]     r_xor, n_xor;
    logic [7:0]     r_cmd, n_cmd;
    logic [AW-1:0]  r_src, n_src;
    logic [AW-1:0]  r_dst, n_dst;
    logic           r_for_us, n_for_us;
    logic           r_start_ok, n_start_ok;
    logic [AW-1:0]  r_own, n_own;
    logic [AW-1:0]  r_peer, n_peer;
    logic [7:0]     r_cap [CAPTURE_DEPTH];

    logic [7:0]     cap_view [CAPTURE_DEPTH];
    logic           cap_we;
    logic [CW-1:0]  cap_idx;
    logic [7:0]     idx;
    logic           is_data;
    logic           pay_last;
    logic [14:0]    prod;
    logic [15:0]    quot;

    assign idx      = r_pos - 8'(lfr_pkg::HEADER_BYTES);
    assign pay_last = ({1'b0, idx} + 9'd1) >= {1'b0, r_len};
    assign is_data  = (r_cmd == lfr_pkg::CMD_DATA) || (r_cmd == lfr_pkg::CMD_DATA_ALT);

    // the first CAPTURE_DEPTH payload bytes of frames that are not streamed out go to the capture store
    assign cap_idx = idx[CW-1:0];
    assign cap_we  = (i_op == lfr_pkg::OP_BYTE) && (r_link != lfr_pkg::LINK_ERROR) &&
                     (r_pos >= 8'(lfr_pkg::HEADER_BYTES)) && !(r_for_us && is_data) &&
                     (idx < 8'(CAPTURE_DEPTH));

    // capture view with the byte of this step already in place
    always_comb begin
        for (int i = 0; i < CAPTURE_DEPTH; i++) begin
            cap_view[i] = (cap_we && cap_idx == CW'(i)) ? i_byte : r_cap[i];
        end
    end

    // percent = byte * 100 / 255 by reciprocal
    assign prod = {7'd0, cap_view[4]} * lfr_pkg::SIGNAL_SCALE;
    assign quot = {1'b0, prod} + 16'd1 + {9'd0, prod[14:8]};

    always_comb begin
        logic           run_ctrl;
        logic           do_fail;
        lfr_pkg::t_beat res;

        run_ctrl   = 1'b0;
        do_fail    = 1'b0;
        res        = '0;
        n_link     = r_link;
        n_pos      = r_pos;
        n_len      = r_len;
        n_xor      = r_xor;
        n_cmd      = r_cmd;
        n_src      = r_src;
        n_dst      = r_dst;
        n_for_us   = r_for_us;
        n_start_ok = r_start_ok;
        n_own      = r_own;
        n_peer     = r_peer;

        case (i_op)
            lfr_pkg::OP_BYTE: begin
                if (r_link != lfr_pkg::LINK_ERROR) begin
                    if (r_pos < 8'(lfr_pkg::HEADER_BYTES)) begin
                        if (r_pos == 8'd0) begin
                            n_start_ok = (i_byte == lfr_pkg::START_BYTE);
                            n_xor      = i_byte;
                        end else if (r_pos < 8'd4) begin
                            n_xor = r_xor ^ i_byte;
                        end
                        if (r_pos == 8'd1) n_len = i_byte;
                        if (r_pos >= 8'd4 && r_pos < 8'd10) n_src = {r_src[AW-9:0], i_byte};
                        if (r_pos >= 8'd10 && r_pos < 8'd16) n_dst = {r_dst[AW-9:0], i_byte};
                        if (r_pos == 8'd16) n_cmd = i_byte;
                        if (r_pos < 8'(lfr_pkg::HEADER_BYTES - 1)) begin
                            n_pos = r_pos + 8'd1;
                        end else if (!r_start_ok || r_xor != 8'd0 ||
                                     r_len < 8'(lfr_pkg::HEADER_BYTES)) begin
                            do_fail = 1'b1;
                        end else begin
                            n_len    = r_len - 8'(lfr_pkg::HEADER_BYTES);
                            n_for_us = (r_dst == r_own) || (r_dst == '0) ||
                                       (r_dst == lfr_pkg::ADDR_ALL);
                            if (n_len != 8'd0) begin
                                n_pos = 8'(lfr_pkg::HEADER_BYTES);
                            end else begin
                                n_pos = 8'd0;
                                if (n_for_us) begin
                                    if (is_data) begin
                                        res.valid = 1'b1;
                                        res.kind  = lfr_pkg::KIND_EMPTY;
                                        res.last  = 1'b1;
                                        res.cmd   = r_cmd;
                                    end else begin
                                        run_ctrl = 1'b1;
                                    end
                                end
                            end
                        end
                    end else begin
                        if (r_for_us && is_data) begin
                            res.valid   = 1'b1;
                            res.kind    = lfr_pkg::KIND_PAYLOAD;
                            res.payload = i_byte;
                            res.last    = pay_last;
                            res.cmd     = r_cmd;
                        end
                        if (!pay_last) begin
                            n_pos = r_pos + 8'd1;
                        end else begin
                            n_pos = 8'd0;
                            if (r_for_us && !is_data) run_ctrl = 1'b1;
                        end
                    end
                end
            end
            lfr_pkg::OP_TIMEOUT: begin
                if (r_link != lfr_pkg::LINK_ERROR && r_pos != 8'd0) do_fail = 1'b1;
            end
            lfr_pkg::OP_CONFIRM: begin
                if (r_link == lfr_pkg::LINK_DEVLIST) begin
                    n_link    = lfr_pkg::LINK_CONNECTED;
                    res.valid = 1'b1;
                    res.kind  = lfr_pkg::KIND_LINK;
                end
            end
            lfr_pkg::OP_RESET: begin
                n_link     = lfr_pkg::LINK_IDLE;
                n_pos      = 8'd0;
                n_len      = 8'd0;
                n_xor      = 8'd0;
                n_for_us   = 1'b0;
                n_start_ok = 1'b0;
            end
            default: begin
            end
        endcase

        // control frames
        if (run_ctrl) begin
            case (r_cmd)
                lfr_pkg::CMD_JOIN: begin
                    if (n_len != lfr_pkg::JOIN_LEN) begin
                        do_fail = 1'b1;
                    end else if (r_link == lfr_pkg::LINK_IDLE) begin
                        n_link    = lfr_pkg::LINK_START;
                        res.valid = 1'b1;
                        res.kind  = lfr_pkg::KIND_LINK;
                    end
                end
                lfr_pkg::CMD_ADDR: begin
                    if (n_len == lfr_pkg::JOIN_LEN && r_link == lfr_pkg::LINK_START) begin
                        n_peer    = {cap_view[0], cap_view[1], cap_view[2],
                                     cap_view[3], cap_view[4], cap_view[5]};
                        n_own     = {cap_view[7], cap_view[8], cap_view[9],
                                     cap_view[10], cap_view[11], cap_view[12]};
                        n_link    = lfr_pkg::LINK_ADDR;
                        res.valid = 1'b1;
                        res.kind  = lfr_pkg::KIND_LINK;
                    end
                end
                lfr_pkg::CMD_DEVLIST: begin
                    if (n_len[2:0] != 3'd0 || n_len < lfr_pkg::DEVLIST_MIN) begin
                        do_fail = 1'b1;
                    end else if (r_link == lfr_pkg::LINK_ADDR) begin
                        n_link      = lfr_pkg::LINK_DEVLIST;
                        res.valid   = 1'b1;
                        res.kind    = lfr_pkg::KIND_LINK;
                        res.devices = n_len[7:3] - 5'd1;
                    end
                end
                lfr_pkg::CMD_SIGNAL: begin
                    if (n_len == lfr_pkg::SIGNAL_LEN && cap_view[0] == lfr_pkg::SIGNAL_TAG) begin
                        res.valid = 1'b1;
                        res.kind  = lfr_pkg::KIND_SIGNAL;
                        res.pct   = quot[14:8];
                    end
                end
                default: begin
                end
            endcase
        end

        if (do_fail) begin
            n_link    = lfr_pkg::LINK_ERROR;
            n_pos     = 8'd0;
            res       = '0;
            res.valid = 1'b1;
            res.kind  = lfr_pkg::KIND_ERROR;
        end

        res.src    = n_src;
        res.own    = n_own;
        res.peer   = n_peer;
        res.status = n_link;
        o_beat     = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= lfr_pkg::LINK_IDLE;
        end else if (i_step) begin
            r_link <= n_link;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_len      <= '0;
            r_xor      <= '0;
            r_cmd      <= '0;
            r_src      <= '0;
            r_dst      <= '0;
            r_for_us   <= 1'b0;
            r_start_ok <= 1'b0;
            r_own      <= '0;
            r_peer     <= '0;
        end else if (i_step) begin
            r_pos      <= n_pos;
            r_len      <= n_len;
            r_xor      <= n_xor;
            r_cmd      <= n_cmd;
            r_src      <= n_src;
            r_dst      <= n_dst;
            r_for_us   <= n_for_us;
            r_start_ok <= n_start_ok;
            r_own      <= n_own;
            r_peer     <= n_peer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && cap_we) begin
            r_cap[cap_idx] <= i_byte;
        end
    end

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_link == lfr_pkg::LINK_ERROR && i_op != lfr_pkg::OP_RESET)
        |=> (r_link == lfr_pkg::LINK_ERROR))
        else $error("link left error state without host reset");

    a_payload_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos >= 8'(lfr_pkg::HEADER_BYTES)) |-> (r_len != 8'd0))
        else $error("payload phase with zero remaining length");

    a_fail_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_beat.valid && o_beat.kind == lfr_pkg::KIND_ERROR)
        |=> (r_link == lfr_pkg::LINK_ERROR && r_pos == 8'd0))
        else $error("error beat without error state");

endmodule

/* src/link_frame_receiver_unit.sv */
// ----------------------------------------------------------------------------
// link_frame_receiver_unit
// link frame receiver: header check, address filter, payload stream, link fsm
// ----------------------------------------------------------------------------
// channel  dir  tdata                         tuser        tlast
// s_axis   in   byte_value[7:0]               operation    -
// m_axis   out  payload,cmd,src,own,peer,...  result_kind  last_of_packet
//
// one item per cycle unless the output stalls: input register, one pass of
// frame logic, result register
// items that cause no result are consumed without an output beat
// a stalled output holds the result register and then the input register
// synchronous active-low reset clears frame and link state, capture bytes kept
// ----------------------------------------------------------------------------
module link_frame_receiver_unit #(
    parameter int CAPTURE_DEPTH = lfr_pkg::CAPTURE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [7:0]                 i_s_axis_tdata,   // byte_value
    input  logic [1:0]                 i_s_axis_tuser,   // operation
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // payload_byte, data_command, source_address, learned_own_address,
    // learned_peer_address, link_status, devices_found, signal_percent, pad
    output logic [lfr_pkg::DATA_W-1:0] o_m_axis_tdata,
    output logic [2:0]                 o_m_axis_tuser,   // result_kind
    output logic                       o_m_axis_tlast    // last_of_packet
);

    logic           r_in_valid;
    lfr_pkg::t_op   r_in_op;
    logic [7:0]     r_in_byte;
    logic           r_out_valid;
    lfr_pkg::t_beat r_out;
    lfr_pkg::t_beat beat;
    logic           out_free;
    logic           step;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign step            = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_op   <= lfr_pkg::t_op'(i_s_axis_tuser);
            r_in_byte <= i_s_axis_tdata;
        end
    end

    lfr_core #(
        .CAPTURE_DEPTH (CAPTURE_DEPTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_op    (r_in_op),
        .i_byte  (r_in_byte),
        .o_beat  (beat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step && beat.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && beat.valid && out_free) begin
            r_out <= beat;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tlast  = r_out.last;
    assign o_m_axis_tdata  = {1'b0, r_out.pct, r_out.devices, r_out.status,
                              r_out.peer, r_out.own, r_out.src, r_out.cmd,
                              r_out.payload};

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_free) |=> r_in_valid)
        else $error("input register dropped a waiting item");

    a_error_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == lfr_pkg::KIND_ERROR)
        |-> (r_out.status == lfr_pkg::LINK_ERROR))
        else $error("error beat without error status");

    a_payload_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.kind == lfr_pkg::KIND_PAYLOAD ||
                         r_out.kind == lfr_pkg::KIND_EMPTY))
        |-> (r_out.cmd == lfr_pkg::CMD_DATA || r_out.cmd == lfr_pkg::CMD_DATA_ALT))
        else $error("data beat from a non-data frame");

endmodule
